// File: design/cov_pkg.sv
// ----------------------------------------------------------------------------
// cov_pkg
// Shared constants, codes and latencies of the circle overlap area pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cov_pkg;

  // Q30 fixed-point constants
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] HPI_Q30 = 32'd1686629713;

  localparam logic [49:0] AREA_MAX = {50{1'b1}};

  // overlap kind codes
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_LENS = 2'd1;
  localparam logic [1:0] KIND_CONT = 2'd2;

  // arccos polynomial, Q30, lowest order first
  localparam logic signed [31:0] ACOS_COEF [8] = '{
    32'sd1686629690, -32'sd230423709, 32'sd95540460, -32'sd53874249,
    32'sd33169905, -32'sd18348235, 32'sd7161954, -32'sd1355590
  };

  // sine series divisors and their floor(2^32 / k) reciprocals
  localparam logic [7:0]  SIN_DIV [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] SIN_RCP [6] = '{
    30'd27531841, 30'd39045157, 30'd59652323,
    30'd102261126, 30'd214748364, 30'd715827882
  };

  // register stages of each unit, input to registered output
  localparam int COS_LAT  = 35;
  localparam int SEG_LAT  = 56;
  localparam int AREA_LAT = 3;

endpackage

`default_nettype wire

// File: design/cov_in_if.sv
// ----------------------------------------------------------------------------
// cov_in_if
// Input channel: one circle pair per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cov_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic [31:0] radius_a;
  logic [31:0] radius_b;
  logic        self_pair;
  logic        last_pair;

  modport source (output valid, distance, radius_a, radius_b, self_pair, last_pair,
                  input ready);
  modport sink   (input valid, distance, radius_a, radius_b, self_pair, last_pair,
                  output ready);
endinterface

`default_nettype wire

// File: design/cov_out_if.sv
// ----------------------------------------------------------------------------
// cov_out_if
// Result channel: overlap area, gap, kind and sweep mark per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cov_out_if;
  logic               valid;
  logic               ready;
  logic [49:0]        overlap_area;
  logic signed [33:0] frontier_gap;
  logic [1:0]         overlap_kind;
  logic               last_result;

  modport source (output valid, overlap_area, frontier_gap, overlap_kind, last_result,
                  input ready);
  modport sink   (input valid, overlap_area, frontier_gap, overlap_kind, last_result,
                  output ready);
endinterface

`default_nettype wire

// File: design/cov_cos.sv
// ----------------------------------------------------------------------------
// cov_cos
// Pipelined law-of-cosines unit: Q30 cosine of the angle between sides p, d.
// ----------------------------------------------------------------------------
`default_nettype none

module cov_cos (
  input  logic               clk,
  input  logic               adv,
  input  logic [30:0]        p_i,
  input  logic [30:0]        q_i,
  input  logic [30:0]        d_i,
  output logic signed [31:0] cos_o
);
  import cov_pkg::*;

  localparam int DIV_N = 30;

  logic [61:0] pp_r, dd_r, qq_r, pd_r;
  logic [62:0] pos_r, den2_r;
  logic [61:0] qq2_r;
  logic [62:0] mag3_r, den3_r;
  logic        neg3_r;

  logic [62:0] r_r   [0:DIV_N];
  logic [62:0] den_r [0:DIV_N];
  logic [29:0] quo_r [0:DIV_N];
  logic        neg_r [0:DIV_N];
  logic        sat_r [0:DIV_N];

  logic signed [31:0] cos_nxt;

  // squares and cross product
  always_ff @(posedge clk) begin
    if (adv) begin
      pp_r <= p_i * p_i;
      dd_r <= d_i * d_i;
      qq_r <= q_i * q_i;
      pd_r <= p_i * d_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r  <= {1'b0, pp_r} + {1'b0, dd_r};
      qq2_r  <= qq_r;
      den2_r <= {pd_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg3_r <= pos_r < {1'b0, qq2_r};
      mag3_r <= (pos_r < {1'b0, qq2_r}) ? ({1'b0, qq2_r} - pos_r) : (pos_r - {1'b0, qq2_r});
      den3_r <= den2_r;
    end
  end

  // clamp decision and divider load
  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r[0] <= (den3_r == '0) || (mag3_r >= den3_r);
      r_r[0]   <= mag3_r;
      den_r[0] <= den3_r;
      quo_r[0] <= '0;
      neg_r[0] <= neg3_r;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar g = 0; g < DIV_N; g++) begin : g_div
    logic [63:0] r2;
    logic        ge;
    always_comb begin
      r2 = {r_r[g], 1'b0};
      ge = r2 >= {1'b0, den_r[g]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        r_r[g+1]   <= ge ? 63'(r2 - {1'b0, den_r[g]}) : r2[62:0];
        quo_r[g+1] <= {quo_r[g][28:0], ge};
        den_r[g+1] <= den_r[g];
        neg_r[g+1] <= neg_r[g];
        sat_r[g+1] <= sat_r[g];
      end
    end
  end

  always_comb begin
    if (sat_r[DIV_N]) begin
      cos_nxt = neg_r[DIV_N] ? -$signed(ONE_Q30) : $signed(ONE_Q30);
    end else begin
      cos_nxt = neg_r[DIV_N] ? -$signed({2'b0, quo_r[DIV_N]})
                             : $signed({2'b0, quo_r[DIV_N]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_o <= cos_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/cov_seg.sv
// ----------------------------------------------------------------------------
// cov_seg
// Pipelined segment term: half of (2*acos(c) - sin(2*acos(c))), Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module cov_seg (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] cos_i,
  output logic [31:0]        half_o
);
  import cov_pkg::*;

  localparam int SQ_N  = 31;
  localparam int HRN_N = 7;
  localparam int SIN_N = 6;

  typedef struct packed {
    logic [31:0] s;
    logic [30:0] psi;
    logic [32:0] phi;
    logic        sneg;
  } sc_t;

  function automatic logic signed [34:0] trunc_q30(input logic signed [64:0] v);
    logic signed [64:0] sh;
    sh = v >>> 30;
    return 35'(sh) + 35'({34'b0, (v[64] && (v[29:0] != '0))});
  endfunction

  // arccos front: |c|, radicand, polynomial and square root side by side
  logic [30:0]        x_r    [0:SQ_N];
  logic               neg_r  [0:SQ_N];
  logic [61:0]        rad_r  [0:SQ_N];
  logic [32:0]        rem_r  [0:SQ_N];
  logic [30:0]        root_r [0:SQ_N];
  logic signed [32:0] p_r    [0:SQ_N];

  logic [31:0] cabs;
  logic [30:0] omx;

  always_comb begin
    cabs = cos_i[31] ? 32'(-cos_i) : cos_i;
    omx  = ONE_Q30[30:0] - cabs[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= cabs[30:0];
      neg_r[0]  <= cos_i[31];
      rad_r[0]  <= {1'b0, omx, 30'b0};
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      p_r[0]    <= 33'(ACOS_COEF[7]);
    end
  end

  for (genvar g = 0; g < SQ_N; g++) begin : g_sq
    logic [34:0]        cur;
    logic [32:0]        trial;
    logic               ge;
    logic signed [32:0] p_nxt;
    always_comb begin
      cur   = {rem_r[g], rad_r[g][61-2*g -: 2]};
      trial = {root_r[g], 2'b01};
      ge    = cur >= {2'b0, trial};
    end
    if (g < HRN_N) begin : g_horn
      logic signed [64:0] hprod;
      always_comb begin
        hprod = p_r[g] * $signed({1'b0, x_r[g]});
        p_nxt = 33'(trunc_q30(hprod) + 35'(ACOS_COEF[HRN_N-1-g]));
      end
    end else begin : g_hold
      always_comb p_nxt = p_r[g];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[g+1]  <= ge ? 33'(cur - {2'b0, trial}) : cur[32:0];
        root_r[g+1] <= {root_r[g][29:0], ge};
        rad_r[g+1]  <= rad_r[g];
        x_r[g+1]    <= x_r[g];
        neg_r[g+1]  <= neg_r[g];
        p_r[g+1]    <= p_nxt;
      end
    end
  end

  // angle = sqrt(1-x) * P(x), mirrored for negative cosines
  logic signed [64:0] bprod_r;
  logic               bneg_r;
  logic [32:0]        phi_r;
  logic signed [34:0] base;
  logic signed [35:0] ang;

  always_ff @(posedge clk) begin
    if (adv) begin
      bprod_r <= $signed({1'b0, root_r[SQ_N]}) * p_r[SQ_N];
      bneg_r  <= neg_r[SQ_N];
    end
  end

  always_comb begin
    base = trunc_q30(bprod_r);
    ang  = bneg_r ? ($signed({4'b0, PI_Q30}) - 36'(base)) : 36'(base);
    if (ang < 0) begin
      ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phi_r <= {ang[31:0], 1'b0};
    end
  end

  // fold phi into [0, pi/2]
  logic [32:0] fold;
  logic        fneg;
  logic [30:0] psi_r;
  logic [32:0] phid_r;
  logic        sneg_r;

  always_comb begin
    fold = phi_r;
    fneg = 1'b0;
    if (fold > {1'b0, PI_Q30}) begin
      fold = fold - {1'b0, PI_Q30};
      fneg = 1'b1;
    end
    if (fold > {1'b0, PI_Q30}) begin
      fold = {1'b0, PI_Q30};
    end
    if (fold > {1'b0, HPI_Q30}) begin
      fold = {1'b0, PI_Q30} - fold;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      psi_r  <= fold[30:0];
      phid_r <= phi_r;
      sneg_r <= fneg;
    end
  end

  logic [61:0] sq_r;
  sc_t         sq_sc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r         <= psi_r * psi_r;
      sq_sc_r.s    <= '0;
      sq_sc_r.psi  <= psi_r;
      sq_sc_r.phi  <= phid_r;
      sq_sc_r.sneg <= sneg_r;
    end
  end

  // nested sine series, three stages a term: product, reciprocal, correction
  sc_t         sc_a_r [SIN_N];
  sc_t         sc_b_r [SIN_N];
  sc_t         sc_c_r [SIN_N];
  logic [31:0] v_a_r  [SIN_N];
  logic [31:0] v_b_r  [SIN_N];
  logic [61:0] qm_b_r [SIN_N];
  logic [30:0] t_c_r  [SIN_N];

  for (genvar k = 0; k < SIN_N; k++) begin : g_sin
    sc_t         sc_in;
    logic [30:0] t_in;
    logic [62:0] st;
    logic [29:0] q0;
    logic [37:0] qk;
    logic [37:0] rm;
    logic [30:0] q;
    if (k == 0) begin : g_first
      always_comb begin
        sc_in   = sq_sc_r;
        sc_in.s = sq_r[61:30];
        t_in    = ONE_Q30[30:0];
      end
    end else begin : g_next
      always_comb begin
        sc_in = sc_c_r[k-1];
        t_in  = t_c_r[k-1];
      end
    end
    always_comb begin
      st = sc_in.s * t_in;
      q0 = qm_b_r[k][61:32];
      qk = q0 * SIN_DIV[k];
      rm = {6'b0, v_b_r[k]} - qk;
      q  = {1'b0, q0} + 31'(rm >= {30'b0, SIN_DIV[k]});
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        v_a_r[k]  <= st[61:30];
        sc_a_r[k] <= sc_in;
        qm_b_r[k] <= v_a_r[k] * SIN_RCP[k];
        v_b_r[k]  <= v_a_r[k];
        sc_b_r[k] <= sc_a_r[k];
        t_c_r[k]  <= ONE_Q30[30:0] - q;
        sc_c_r[k] <= sc_b_r[k];
      end
    end
  end

  logic [61:0]        sn_r;
  sc_t                fin_r;
  logic [30:0]        sinv;
  logic signed [34:0] f;

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_r  <= sc_c_r[SIN_N-1].psi * t_c_r[SIN_N-1];
      fin_r <= sc_c_r[SIN_N-1];
    end
  end

  // phi - sin(phi), clamp at zero, halve
  always_comb begin
    sinv = sn_r[60:30];
    f    = fin_r.sneg ? $signed({2'b0, fin_r.phi} + {4'b0, sinv})
                      : $signed({2'b0, fin_r.phi} - {4'b0, sinv});
    if (f < 0) begin
      f = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      half_o <= f[32:1];
    end
  end

endmodule

`default_nettype wire

// File: design/cov_area.sv
// ----------------------------------------------------------------------------
// cov_area
// Pipelined area term: (r^2 * k) / 2^46 from split partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module cov_area (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] r_i,
  input  logic [31:0] k_i,
  output logic [50:0] term_o
);
  logic [63:0] sq_r;
  logic [31:0] k_r;
  logic [63:0] ph_r, pl_r;
  logic [64:0] acc;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= r_i * r_i;
      k_r  <= k_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r <= sq_r[63:32] * k_r;
      pl_r <= sq_r[31:0] * k_r;
    end
  end

  always_comb acc = {1'b0, ph_r} + {33'b0, pl_r[63:32]};

  always_ff @(posedge clk) begin
    if (adv) begin
      term_o <= acc[64:14];
    end
  end

endmodule

`default_nettype wire

// File: design/circle_overlap_area.sv
// ----------------------------------------------------------------------------
// circle_overlap_area
// Overlap area of two circles from centre distance and radii, one pair a cycle unless held.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake      Word
//   in_ch    in   valid/ready    distance, radius_a, radius_b, self_pair, last_pair
//   out_ch   out  valid/ready    overlap_area, frontier_gap, overlap_kind, last_result
//
// One word is taken every cycle unless the pipeline holds. A result passes the
// input register, the 30-stage cosine divider, the 31-stage square root of the
// arccos unit, the six sine terms of three stages each and the area unit.
// Reset (rst_n low at a clock edge) clears every valid bit, the result valid
// included; data registers, the result data among them, are not reset.
// While a result waits in the output register and out_ch.ready is low, the
// whole pipeline holds and in_ch.ready is low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_overlap_area (
  input  logic clk,
  input  logic rst_n,
  cov_in_if.sink    in_ch,
  cov_out_if.source out_ch
);
  import cov_pkg::*;

  localparam int TOT = COS_LAT + SEG_LAT + AREA_LAT;
  localparam int TAP = COS_LAT + SEG_LAT - 1;

  typedef struct packed {
    logic        last;
    logic [33:0] gap;
    logic [1:0]  kind;
    logic [31:0] ra;
    logic [31:0] rb;
    logic [31:0] lo;
  } sb_t;

  logic adv;
  logic out_vld_r;

  // advance everything whenever the result register is free or being taken
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // input register
  logic        in_vld_r;
  logic [31:0] d_r, ra_r, rb_r;
  logic        self_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r    <= in_ch.distance;
      ra_r   <= in_ch.radius_a;
      rb_r   <= in_ch.radius_b;
      self_r <= in_ch.self_pair;
      last_r <= in_ch.last_pair;
    end
  end

  // classify the pair and prepare the cosine operands
  logic [32:0] sum;
  logic [31:0] lo, hi;
  logic        active, contained, sh;
  logic [30:0] ds, as_w, bs;
  sb_t         sb_nxt;

  always_comb begin
    sum       = {1'b0, ra_r} + {1'b0, rb_r};
    lo        = (ra_r < rb_r) ? ra_r : rb_r;
    hi        = (ra_r < rb_r) ? rb_r : ra_r;
    active    = !self_r && ({1'b0, d_r} < sum);
    contained = ({1'b0, d_r} + {1'b0, lo}) <= {1'b0, hi};
    // halve all three for the cosine step when any uses the top bit
    sh        = d_r[31] | ra_r[31] | rb_r[31];
    ds        = sh ? d_r[31:1]  : d_r[30:0];
    as_w      = sh ? ra_r[31:1] : ra_r[30:0];
    bs        = sh ? rb_r[31:1] : rb_r[30:0];

    sb_nxt.last = last_r;
    sb_nxt.gap  = {2'b0, d_r} - {1'b0, sum};
    sb_nxt.ra   = ra_r;
    sb_nxt.rb   = rb_r;
    sb_nxt.lo   = lo;
    if (!active) begin
      sb_nxt.kind = KIND_NONE;
    end else if (contained) begin
      sb_nxt.kind = KIND_CONT;
    end else begin
      sb_nxt.kind = KIND_LENS;
    end
  end

  // side band travels alongside the arithmetic units
  logic vld_r [0:TOT-1];
  sb_t  sb_r  [0:TOT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_vld_r;
      for (int i = 1; i < TOT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= sb_nxt;
      for (int i = 1; i < TOT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // chord angles at both centres
  logic signed [31:0] cos_b, cos_a;
  logic [31:0]        hb, ha;
  logic [50:0]        tb, ta, tc;

  cov_cos u_cos_b (.clk(clk), .adv(adv), .p_i(bs),   .q_i(as_w), .d_i(ds), .cos_o(cos_b));
  cov_cos u_cos_a (.clk(clk), .adv(adv), .p_i(as_w), .q_i(bs),   .d_i(ds), .cos_o(cos_a));

  cov_seg u_seg_b (.clk(clk), .adv(adv), .cos_i(cos_b), .half_o(hb));
  cov_seg u_seg_a (.clk(clk), .adv(adv), .cos_i(cos_a), .half_o(ha));

  // lens terms and the contained disc
  cov_area u_area_b (.clk(clk), .adv(adv), .r_i(sb_r[TAP].rb), .k_i(hb),     .term_o(tb));
  cov_area u_area_a (.clk(clk), .adv(adv), .r_i(sb_r[TAP].ra), .k_i(ha),     .term_o(ta));
  cov_area u_area_c (.clk(clk), .adv(adv), .r_i(sb_r[TAP].lo), .k_i(PI_Q30), .term_o(tc));

  // pick the area by kind and saturate
  logic [51:0] lens_sum;
  logic [49:0] area_nxt;

  always_comb begin
    lens_sum = {1'b0, ta} + {1'b0, tb};
    case (sb_r[TOT-1].kind)
      KIND_LENS: area_nxt = (lens_sum > {2'b0, AREA_MAX}) ? AREA_MAX : lens_sum[49:0];
      KIND_CONT: area_nxt = (tc > {1'b0, AREA_MAX}) ? AREA_MAX : tc[49:0];
      default:   area_nxt = '0;
    endcase
  end

  // result register
  logic [49:0] area_r;
  logic [33:0] gap_r;
  logic [1:0]  kind_r;
  logic        lastr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      area_r  <= area_nxt;
      gap_r   <= sb_r[TOT-1].gap;
      kind_r  <= sb_r[TOT-1].kind;
      lastr_r <= sb_r[TOT-1].last;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.overlap_area = area_r;
  assign out_ch.frontier_gap = $signed(gap_r);
  assign out_ch.overlap_kind = kind_r;
  assign out_ch.last_result  = lastr_r;

endmodule

`default_nettype wire

// File: tb/circle_overlap_area_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_overlap_area_tb
// Self-checking bench for the circle overlap area pipeline. Circle pairs are
// pushed through the input channel with random gaps, bar a last flat-out run.
// Each pair's area, gap, kind and sweep mark are predicted in fixed point and
// compared, in order, with the result words, under random back-pressure until that run.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_overlap_area_tb;
  import cov_pkg::*;

  typedef struct packed {
    logic [49:0] area;
    logic [33:0] gap;
    logic [1:0]  kind;
    logic        last;
  } overlap_word_t;

  // Signed 64-bit copies of the Q30 constants; keep the arithmetic signed
  localparam longint ONE_L = 64'sd1073741824;
  localparam longint PI_L  = 64'sd3373259426;
  localparam longint HPI_L = 64'sd1686629713;
  localparam int     IDLE_LIMIT   = 3000;  // cycles with no word moving
  localparam int     SETTLE_CYCLES = 200; // wait after the last result before the summary

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cov_in_if  in_ch ();
  cov_out_if out_ch ();

  circle_overlap_area dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  overlap_word_t pending_areas[$];
  int  mismatches = 0;
  int  pairs_sent = 0;
  int  seen_none = 0, seen_lens = 0, seen_cont = 0;
  bit  idling_on = 1'b1;
  bit  failed = 1'b0;
  int  quiet_cycles = 0;
  int  out_stall = 0;

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Cosine at the corner whose adjacent sides are p and dd, opposite side q
  function automatic longint corner_cosine(logic [63:0] p, logic [63:0] q, logic [63:0] dd);
    logic [63:0] pos, neg, den, mag, r, quo;
    bit negv;
    pos  = p * p + dd * dd;
    neg  = q * q;
    den  = 64'd2 * p * dd;
    negv = pos < neg;
    mag  = negv ? neg - pos : pos - neg;
    // clamp to +-1, including the degenerate zero denominator
    if (den == 64'd0 || mag >= den) return negv ? -ONE_L : ONE_L;
    r   = mag;
    quo = 64'd0;
    for (int i = 0; i < 30; i++) begin
      r   = r << 1;
      quo = quo << 1;
      if (r >= den) begin
        r      = r - den;
        quo[0] = 1'b1;
      end
    end
    return negv ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic longint arc_cosine(longint c);
    longint x, poly, base, ang;
    logic [63:0] root;
    x    = (c < 0) ? -c : c;
    poly = longint'(ACOS_COEF[7]);
    for (int k = 6; k >= 0; k--) poly = (poly * x) / ONE_L + longint'(ACOS_COEF[k]);
    root = floor_sqrt(64'(ONE_L - x) << 30);
    base = (longint'(root) * poly) / ONE_L;
    ang  = (c < 0) ? PI_L - base : base;
    if (ang < 0) ang = 0;
    return ang;
  endfunction

  function automatic longint series_sine(logic [63:0] phi);
    logic [63:0] psi, s, t;
    bit negv;
    psi  = phi;
    negv = 1'b0;
    t    = 64'(ONE_L);
    if (psi > 64'(PI_L)) begin
      psi  = psi - 64'(PI_L);
      negv = 1'b1;
    end
    if (psi > 64'(PI_L)) psi = 64'(PI_L);
    if (psi > 64'(HPI_L)) psi = 64'(PI_L) - psi;
    s = (psi * psi) >> 30;
    for (int k = 0; k < 6; k++) t = 64'(ONE_L) - ((s * t) >> 30) / 64'(SIN_DIV[k]);
    t = (psi * t) >> 30;
    return negv ? -longint'(t) : longint'(t);
  endfunction

  // Half of (2 theta - sin 2 theta), Q30
  function automatic logic [63:0] half_lens(longint c);
    longint phi, f;
    phi = 2 * arc_cosine(c);
    f   = phi - series_sine(64'(phi));
    if (f < 0) f = 0;
    return 64'(f) >> 1;
  endfunction

  // r2 (Q32.32) times a Q30 factor, brought to Q16
  function automatic logic [63:0] scale_area(logic [63:0] r2, logic [63:0] k);
    logic [63:0] hi, lo;
    hi = r2 >> 32;
    lo = {32'd0, r2[31:0]};
    return (hi * k + ((lo * k) >> 32)) >> 14;
  endfunction

  function automatic overlap_word_t predict_overlap(logic [31:0] centre_d, logic [31:0] rad_a,
                                                    logic [31:0] rad_b, logic self_p,
                                                    logic last_p);
    logic [63:0] d, ra, rb, sum, area, rmin, rmax, ds, as, bs;
    overlap_word_t w;
    d    = 64'(centre_d);
    ra   = 64'(rad_a);
    rb   = 64'(rad_b);
    sum  = ra + rb;
    area = 64'd0;
    rmin = (ra < rb) ? ra : rb;
    rmax = (ra < rb) ? rb : ra;
    w.kind = KIND_NONE;
    if (!self_p && d < sum) begin
      if (d + rmin <= rmax) begin
        w.kind = KIND_CONT;
        area   = scale_area(rmin * rmin, 64'(PI_L));
      end else begin
        // halve everything for the cosine step when any value uses bit 31
        if (centre_d[31] | rad_a[31] | rad_b[31]) begin
          ds = d >> 1; as = ra >> 1; bs = rb >> 1;
        end else begin
          ds = d; as = ra; bs = rb;
        end
        w.kind = KIND_LENS;
        area   = scale_area(rb * rb, half_lens(corner_cosine(bs, as, ds)))
               + scale_area(ra * ra, half_lens(corner_cosine(as, bs, ds)));
      end
      if (area > 64'(AREA_MAX)) area = 64'(AREA_MAX);
    end
    w.area = area[49:0];
    w.gap  = 34'(d - sum);
    w.last = last_p;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one pair per call, with an optional random gap in front
  // --------------------------------------------------------------------------
  task automatic send_pair(logic [31:0] centre_d, logic [31:0] rad_a, logic [31:0] rad_b,
                           logic self_p, logic last_p);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.distance  <= centre_d;
    in_ch.radius_a  <= rad_a;
    in_ch.radius_b  <= rad_b;
    in_ch.self_pair <= self_p;
    in_ch.last_pair <= last_p;
    // hold the word until it is taken
    do @(posedge clk); while (!in_ch.ready);
    pending_areas.push_back(predict_overlap(centre_d, rad_a, rad_b, self_p, last_p));
    pairs_sent++;
  endtask

  // Hold the input idle until every outstanding word has come back
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk);
  endtask

  // Random magnitude: full word shifted down a random amount
  function automatic logic [31:0] rand_mag();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // Pair whose distance lies between |ra - rb| and ra + rb, so mostly lenses
  task automatic send_lens_pair();
    logic [31:0] ra, rb;
    logic [32:0] lo_d, hi_d;
    ra   = rand_mag();
    rb   = ($urandom_range(0, 1) == 1) ? ra + $urandom_range(0, 65535) - 32768 : rand_mag();
    lo_d = (ra > rb) ? 33'(ra - rb) : 33'(rb - ra);
    hi_d = 33'(ra) + 33'(rb);
    if (hi_d > 33'hFFFFFFFF) hi_d = 33'hFFFFFFFF;
    if (lo_d > hi_d) lo_d = hi_d;
    send_pair(32'(64'(lo_d) + ((64'($urandom) * 64'(hi_d - lo_d + 33'd1)) >> 32)), ra, rb,
              $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_pair(32'd0, 32'd0, 32'd0, 1'b0, 1'b0);                       // all zero
    send_pair('1, '1, '1, 1'b0, 1'b1);                                 // all ones
    send_pair('1, '1, '1, 1'b1, 1'b0);                                 // self pair
    send_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1); // self pair, overlap
    send_pair(32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, 1'b0); // gap exactly zero
    send_pair(32'h0009_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0); // apart
    send_pair(32'd0, 32'h0003_0000, 32'h0005_0000, 1'b0, 1'b0);         // concentric
    send_pair(32'h0002_0000, 32'h0003_0000, 32'h0005_0000, 1'b0, 1'b0); // internal touch
    send_pair(32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 1'b0, 1'b0); // b inside a
    send_pair(32'h0003_0000, 32'h0002_0000, 32'h0002_0000, 1'b0, 1'b0); // equal lens
    send_pair(32'h0003_0000, 32'h000A_0000, 32'h0008_0000, 1'b0, 1'b0); // obtuse corner
    send_pair(32'h0000_0100, 32'h0000_00C0, 32'h0000_0080, 1'b0, 1'b1); // tiny lens
    send_pair(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0); // cosine 0/0
    send_pair(32'hF000_0000, 32'hA000_0000, 32'h9000_0000, 1'b0, 1'b0); // halved cosine
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0); // just below halving
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0); // big thin lens
    send_pair(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1); // huge, near-full lens
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0); // alternating bits
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1);
  endtask

  task automatic test_random_lenses(int n);
    repeat (n) send_lens_pair();
  endtask

  task automatic test_random_noise(int n);
    repeat (n) send_pair($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
  endtask

  task automatic test_scaled_mix(int n);
    repeat (n) send_pair(rand_mag(), rand_mag(), rand_mag(), $urandom_range(0, 7) == 0,
                         1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, then check against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      out_stall    <= 0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      out_stall    <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    overlap_word_t exp_w, got_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_w = '{out_ch.overlap_area, out_ch.frontier_gap, out_ch.overlap_kind,
                out_ch.last_result};
      if (pending_areas.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result word area=%h gap=%h kind=%0d last=%b",
                   got_w.area, got_w.gap, got_w.kind, got_w.last);
      end else begin
        exp_w = pending_areas.pop_front();
        case (exp_w.kind)
          KIND_LENS: seen_lens++;
          KIND_CONT: seen_cont++;
          default:   seen_none++;
        endcase
        if (got_w !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: area exp %h got %h, gap exp %h got %h, kind exp %0d got %0d, last exp %b got %b",
                     exp_w.area, got_w.area, exp_w.gap, got_w.gap,
                     exp_w.kind, got_w.kind, exp_w.last, got_w.last);
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.distance  = '0;
    in_ch.radius_a  = '0;
    in_ch.radius_b  = '0;
    in_ch.self_pair = 1'b0;
    in_ch.last_pair = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain_pipeline();
    test_random_lenses(400);
    test_random_noise(120);
    drain_pipeline();
    test_scaled_mix(130);
    // last stretch runs flat out on both sides
    idling_on = 1'b0;
    test_random_lenses(150);
    in_ch.valid <= 1'b0;

    while (pending_areas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d circle pairs: %0d lens, %0d contained, %0d without overlap.",
             pairs_sent, seen_lens, seen_cont, seen_none);
    $display("Mismatching result words: %0d.", mismatches);
    failed = (mismatches != 0) || (pending_areas.size() != 0);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/cov_pkg.sv
design/cov_in_if.sv
design/cov_out_if.sv
design/cov_cos.sv
design/cov_seg.sv
design/cov_area.sv
design/circle_overlap_area.sv
tb/circle_overlap_area_tb.sv
